// ===== sv/fire_heat_effect_assert.svh =====
`ifndef FIRE_HEAT_EFFECT_ASSERT_SVH
`define FIRE_HEAT_EFFECT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define FHE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fire_heat_effect: check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define FHE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fire_heat_effect: check failed");

`endif

// ===== sv/fhe_pkg.sv =====
package fhe_pkg;

  localparam int NUM_CELLS_DEF  = 32;
  localparam int SPARK_ZONE_DEF = 7;

  localparam int HEAT_W    = 8;
  localparam int PIXEL_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int TICK_W    = 8;
  localparam int SPAN_W    = 9;
  localparam int ELAPSED_W = 17;
  localparam int LFSR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LFSR_W-1:0]    LFSR_TAPS   = 16'hB400;
  localparam logic [LFSR_W-1:0]    SEED_RESET  = 16'd44257;
  localparam logic [7:0]           COOL_RESET  = 8'd55;
  localparam logic [7:0]           SPARK_RESET = 8'd120;
  localparam logic [15:0]          DELAY_RESET = 16'd15;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [HEAT_W-1:0]    SPARK_BASE  = 8'd160;
  localparam logic [SPAN_W-1:0]    SPAN_SPARK  = 9'd255;
  localparam logic [SPAN_W-1:0]    SPAN_AMOUNT = 9'd95;

  localparam logic [CFG_IDX_W-1:0] CFG_COOLING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_COOL_RD,
    ST_COOL_WR,
    ST_DIF_PRE_RD,
    ST_DIF_PRE_WR,
    ST_DIF_RD,
    ST_DIF_WR,
    ST_SPK_TEST,
    ST_SPK_CHK,
    ST_SPK_Y,
    ST_SPK_AMT,
    ST_SPK_ADD,
    ST_OUT_RD,
    ST_OUT_WR
  } state_t;

  typedef struct packed {
    logic              step;
    logic [SPAN_W-1:0] span;
    logic              load;
    logic [LFSR_W-1:0] seed;
  } rng_ctrl_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  // (a + 2b) / 3 for sums up to 765, by reciprocal 683 / 2^11
  function automatic logic [HEAT_W-1:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // round(h * 191 / 255), folded into one multiply by 191 * ceil(2^24 / 255)
  function automatic logic [7:0] heat_t(input logic [HEAT_W-1:0] h);
    logic [31:0] p;
    p = 32'(h) * 32'd12566654 + 32'd8355838;
    return p[31:24];
  endfunction

  function automatic rgb_t heat_color(input logic [HEAT_W-1:0] h);
    logic [7:0]   t;
    logic [7:0]   ramp;
    rgb_t         c;
    t    = heat_t(h);
    ramp = {t[5:0], 2'b00};
    if (t > 8'h80) begin
      c = '{r: 8'hFF, g: 8'hFF, b: ramp};
    end else if (t > 8'h40) begin
      c = '{r: 8'hFF, g: ramp, b: 8'h00};
    end else begin
      c = '{r: ramp, g: 8'h00, b: 8'h00};
    end
    return c;
  endfunction

endpackage

// ===== sv/fhe_ifs.sv =====
interface fhe_tick_if;
  import fhe_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] ticks;

  modport source (output valid, output ticks, input ready);
  modport sink (input valid, input ticks, output ready);
endinterface

interface fhe_pixel_if;
  import fhe_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               last_pixel;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input red, input green,
                input blue, input last_pixel, output ready);
endinterface

// ===== sv/fire_heat_effect.sv =====
// Fire effect on a column of NUM_CELLS heat cells, driven by millisecond ticks.
// A tick that does not push the elapsed count past frame_delay only updates the
// count. A tick that does starts a frame, and tick.ready stays low until the
// frame's last pixel has been loaded into the output register; the pixel sink
// can hold that off by keeping ready low. Because the heat RAM's read is
// registered, each of the three walks over the cells (cooling, upward drift,
// colour output) uses a read state and a write state for each cell, with one
// shared LFSR draw unit supplying every random value.
// Pixels leave cell 0 first; last_pixel marks the top cell. Configuration
// writes take effect at once; a seed write reloads the generator.
`include "fire_heat_effect_assert.svh"

module fire_heat_effect #(
  parameter int NUM_CELLS  = fhe_pkg::NUM_CELLS_DEF,
  parameter int SPARK_ZONE = fhe_pkg::SPARK_ZONE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  fhe_tick_if.sink                       tick,
  fhe_pixel_if.source                    pixel,
  input  logic                           cfg_we,
  input  logic [fhe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fhe_pkg::*;

  localparam int IDX_W = $clog2(NUM_CELLS);
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP = (2 ** RECIP_SHIFT + NUM_CELLS - 1) / NUM_CELLS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CELLS - 1);
  localparam logic [IDX_W-1:0] PRE_IDX  = IDX_W'(NUM_CELLS - 2);
  localparam logic [IDX_W-1:0] DIF_END  = IDX_W'(2);
  localparam logic [SPAN_W-1:0] SPAN_ZONE = SPAN_W'(SPARK_ZONE);

  state_t state;
  state_t state_next;

  logic [7:0]           cooling;
  logic [7:0]           spark_chance;
  logic [15:0]          frame_delay;
  logic [ELAPSED_W-1:0] elapsed;
  logic [SPAN_W-1:0]    span;
  logic [IDX_W-1:0]     idx;
  logic [HEAT_W-1:0]    above;
  logic [IDX_W-1:0]     spark_y;

  logic [NUM_CELLS-1:0] cell_valid;
  logic                 rd_valid;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [HEAT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [HEAT_W-1:0]    ram_rdata;
  logic [HEAT_W-1:0]    heat_rd;

  rng_ctrl_t         rng_ctrl;
  logic [SPAN_W-1:0] draw;

  logic                 out_valid;
  logic [PIXEL_W-1:0]   out_index;
  rgb_t                 out_rgb;
  logic                 out_last;
  logic                 out_free;
  rgb_t                 cell_rgb;

  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 tick_acc;
  logic                 frame_start;
  logic [11:0]          cool_x10;
  logic [28:0]          span_prod;
  logic [9:0]           drift_sum;

  fhe_ram #(
    .WIDTH (HEAT_W),
    .DEPTH (NUM_CELLS)
  ) u_heat (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fhe_rng u_rng (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rng_ctrl),
    .draw (draw)
  );

  // cells never written read as cold
  assign heat_rd  = rd_valid ? ram_rdata : '0;
  assign out_free = !out_valid || pixel.ready;
  assign cell_rgb = heat_color(heat_rd);

  assign tick.ready  = (state == ST_IDLE);
  assign tick_acc    = tick.valid && tick.ready;
  assign elapsed_sum = {1'b0, elapsed} + (ELAPSED_W+1)'(tick.ticks);
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
  assign frame_start = tick_acc && (elapsed_sat > ELAPSED_W'(frame_delay));

  assign cool_x10  = {1'b0, cooling, 3'b000} + {3'b000, cooling, 1'b0};
  assign span_prod = 29'(cool_x10) * 29'(RECIP);
  assign drift_sum = 10'(above) + {1'b0, heat_rd, 1'b0};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (frame_start) begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN:       state_next = ST_COOL_RD;
      ST_COOL_RD:    state_next = ST_COOL_WR;
      ST_COOL_WR:    state_next = (idx == LAST_IDX) ? ST_DIF_PRE_RD : ST_COOL_RD;
      ST_DIF_PRE_RD: state_next = ST_DIF_PRE_WR;
      ST_DIF_PRE_WR: state_next = ST_DIF_RD;
      ST_DIF_RD:     state_next = ST_DIF_WR;
      ST_DIF_WR:     state_next = (idx == DIF_END) ? ST_SPK_TEST : ST_DIF_RD;
      ST_SPK_TEST:   state_next = ST_SPK_CHK;
      ST_SPK_CHK: begin
        state_next = (draw < SPAN_W'(spark_chance)) ? ST_SPK_Y : ST_OUT_RD;
      end
      ST_SPK_Y:      state_next = ST_SPK_AMT;
      ST_SPK_AMT:    state_next = ST_SPK_ADD;
      ST_SPK_ADD:    state_next = ST_OUT_RD;
      ST_OUT_RD:     state_next = ST_OUT_WR;
      ST_OUT_WR: begin
        if (out_free) begin
          state_next = (idx == LAST_IDX) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = heat_rd;
    ram_raddr     = idx;
    rng_ctrl.step = 1'b0;
    rng_ctrl.span = span;
    rng_ctrl.load = cfg_we && (cfg_index == CFG_SEED);
    rng_ctrl.seed = cfg_data[LFSR_W-1:0];
    case (state)
      ST_COOL_RD: begin
        rng_ctrl.step = 1'b1;
      end
      ST_COOL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (draw > SPAN_W'(heat_rd)) ? '0 : heat_rd - draw[HEAT_W-1:0];
      end
      ST_DIF_PRE_RD: begin
        ram_raddr = PRE_IDX;
      end
      ST_DIF_RD: begin
        ram_raddr = idx - DIF_END;
      end
      ST_DIF_WR: begin
        ram_we    = 1'b1;
        ram_wdata = div3(drift_sum);
      end
      ST_SPK_TEST: begin
        rng_ctrl.step = 1'b1;
        rng_ctrl.span = SPAN_SPARK;
      end
      ST_SPK_Y: begin
        rng_ctrl.step = 1'b1;
        rng_ctrl.span = SPAN_ZONE;
      end
      ST_SPK_AMT: begin
        ram_raddr     = draw[IDX_W-1:0];
        rng_ctrl.step = 1'b1;
        rng_ctrl.span = SPAN_AMOUNT;
      end
      ST_SPK_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = spark_y;
        // wraps modulo 256
        ram_wdata = heat_rd + SPARK_BASE + draw[HEAT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooling      <= COOL_RESET;
      spark_chance <= SPARK_RESET;
      frame_delay  <= DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COOLING: cooling      <= cfg_data[7:0];
        CFG_SPARK:   spark_chance <= cfg_data[7:0];
        CFG_DELAY:   frame_delay  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (tick_acc) begin
      elapsed <= frame_start ? '0 : elapsed_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else if (ram_we) begin
      cell_valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= cell_valid[ram_raddr];
  end

  // walk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (state)
        ST_SPAN:       idx <= '0;
        ST_COOL_WR:    idx <= (idx == LAST_IDX) ? LAST_IDX : idx + 1'b1;
        ST_DIF_WR:     idx <= idx - 1'b1;
        ST_SPK_CHK:    idx <= '0;
        ST_SPK_ADD:    idx <= '0;
        ST_OUT_WR: begin
          if (out_free && idx != LAST_IDX) begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SPAN) begin
      span <= span_prod[RECIP_SHIFT +: SPAN_W] + SPAN_W'(2);
    end
    if (state == ST_DIF_PRE_WR || state == ST_DIF_WR) begin
      above <= heat_rd;
    end
    if (state == ST_SPK_AMT) begin
      spark_y <= draw[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT_WR && out_free) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT_WR && out_free) begin
      out_index <= PIXEL_W'(idx);
      out_rgb   <= cell_rgb;
      out_last  <= (idx == LAST_IDX);
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_index = out_index;
  assign pixel.red         = out_rgb.r;
  assign pixel.green       = out_rgb.g;
  assign pixel.blue        = out_rgb.b;
  assign pixel.last_pixel  = out_last;

  `FHE_ASSERT_NEXT(a_quiet_tick_stays_idle, tick_acc && !frame_start, state == ST_IDLE)
  `FHE_ASSERT_NEXT(a_frame_clears_elapsed, frame_start, elapsed == '0 && state == ST_SPAN)
  `FHE_ASSERT_NEXT(a_last_pixel_marked, state == ST_OUT_WR && out_free && idx == LAST_IDX, pixel.valid && pixel.last_pixel)
  `FHE_ASSERT_NOW(a_cool_span_floor, state == ST_COOL_RD, span >= SPAN_W'(2))

endmodule

// ===== sv/fhe_ram.sv =====
module fhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fhe_rng.sv =====
module fhe_rng (
  input  logic                      clk,
  input  logic                      rst,
  input  fhe_pkg::rng_ctrl_t        ctrl,
  output logic [fhe_pkg::SPAN_W-1:0] draw
);
  import fhe_pkg::*;

  logic [LFSR_W-1:0]        lfsr;
  logic [LFSR_W-1:0]        lfsr_next;
  logic [LFSR_W+SPAN_W-1:0] prod;

  always_comb begin
    lfsr_next = {1'b0, lfsr[LFSR_W-1:1]};
    if (lfsr[0]) begin
      lfsr_next = lfsr_next ^ LFSR_TAPS;
    end
    prod = (LFSR_W+SPAN_W)'(lfsr_next) * (LFSR_W+SPAN_W)'(ctrl.span);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_RESET;
    end else if (ctrl.load) begin
      // never let the generator lock up on zero
      lfsr <= (ctrl.seed == '0) ? LFSR_W'(1) : ctrl.seed;
    end else if (ctrl.step) begin
      lfsr <= lfsr_next;
    end
  end

  // scaled draw in [0, span), held until the next step
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      draw <= prod[LFSR_W +: SPAN_W];
    end
  end

endmodule

// ===== tb/tb_fire_heat_effect.sv =====
module tb_fire_heat_effect;
  import fhe_pkg::*;

  localparam int CELLS      = NUM_CELLS_DEF;
  localparam int ZONE       = SPARK_ZONE_DEF;
  localparam int IDLE_PCT   = 34;
  localparam int SETTLE_CYC = 16;
  localparam int CYCLE_MAX  = 2_000_000;

  typedef struct packed {
    logic [PIXEL_W-1:0] idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fhe_tick_if  tick_if ();
  fhe_pixel_if pix_if ();

  fire_heat_effect u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_if),
    .pixel     (pix_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state and register copies
  logic [HEAT_W-1:0]    heat_q [CELLS];
  int unsigned          elapsed_q;
  logic [LFSR_W-1:0]    lfsr_q;
  logic [7:0]           cooling_q;
  logic [7:0]           spark_q;
  logic [15:0]          delay_q;

  pixel_t      pixel_q [$];
  int unsigned errors;
  int unsigned cycle_count;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned lfsr_draw(input int unsigned span);
    logic shifted_out;
    shifted_out = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (shifted_out) begin
      lfsr_q = lfsr_q ^ LFSR_TAPS;
    end
    return (32'(lfsr_q) * span) >> 16;
  endfunction

  function automatic pixel_t colour_pixel(input int unsigned pix_num, input logic [7:0] h);
    int unsigned level;
    logic [7:0]  ramp;
    pixel_t      px;
    level = (32'(h) * 191 + 127) / 255;
    ramp  = 8'((level & 32'h3F) << 2);
    px.idx  = PIXEL_W'(pix_num);
    px.last = (pix_num == CELLS - 1);
    if (level > 32'h80) begin
      px.red = 8'hFF; px.green = 8'hFF; px.blue = ramp;
    end else if (level > 32'h40) begin
      px.red = 8'hFF; px.green = ramp;  px.blue = 8'h00;
    end else begin
      px.red = ramp;  px.green = 8'h00; px.blue = 8'h00;
    end
    return px;
  endfunction

  // Advance the elapsed count and, when a frame fires, queue its pixels.
  function automatic void predict_tick(input logic [7:0] ms);
    int unsigned span;
    int unsigned cool;
    int unsigned y;
    int unsigned add;
    elapsed_q = elapsed_q + ms;
    if (elapsed_q > ELAPSED_MAX) begin
      elapsed_q = ELAPSED_MAX;
    end
    if (elapsed_q <= delay_q) begin
      return;
    end
    elapsed_q = 0;
    span = 32'(cooling_q) * 10 / CELLS + 2;
    for (int i = 0; i < CELLS; i++) begin
      cool = lfsr_draw(span);
      heat_q[i] = (cool > heat_q[i]) ? 8'd0 : 8'(heat_q[i] - cool);
    end
    for (int i = CELLS - 1; i >= 2; i--) begin
      heat_q[i] = 8'((32'(heat_q[i-1]) + 2 * 32'(heat_q[i-2])) / 3);
    end
    if (lfsr_draw(255) < spark_q) begin
      y   = lfsr_draw(ZONE);
      add = 160 + lfsr_draw(95);
      if (y < CELLS) begin
        heat_q[y] = 8'(32'(heat_q[y]) + add);
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      pixel_q.push_back(colour_pixel(i, heat_q[i]));
    end
  endfunction

  // Item is committed once valid rises, so predict here, ahead of the
  // first pixel of any frame it starts.
  task automatic send_tick(input logic [7:0] ms);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    predict_tick(ms);
    tick_if.valid <= 1'b1;
    tick_if.ticks <= ms;
    do @(posedge clk); while (!tick_if.ready);
  endtask

  task automatic drain_pixels();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COOLING: cooling_q = data[7:0];
      CFG_SPARK:   spark_q   = data[7:0];
      CFG_DELAY:   delay_q   = data;
      CFG_SEED:    lfsr_q    = (data == 16'd0) ? 16'd1 : data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [7:0] cool, input logic [7:0] spark,
                           input logic [15:0] delay, input logic [15:0] seed);
    drain_pixels();
    write_reg(CFG_COOLING, 16'(cool));
    write_reg(CFG_SPARK, 16'(spark));
    write_reg(CFG_DELAY, delay);
    write_reg(CFG_SEED, seed);
  endtask

  // Reset settings: zero ticks, delay boundary, tick extremes
  task automatic test_reset_settings();
    logic [7:0] seq [12];
    seq = '{8'd0, 8'd15, 8'd1, 8'd255, 8'd128, 8'd127, 8'd16, 8'd15,
            8'd1, 8'd0, 8'd85, 8'd170};
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  task automatic test_register_extremes();
    // No cooling, sparks always, a frame on every nonzero tick, zero seed
    write_all(8'd0, 8'd255, 16'd0, 16'd0);
    send_tick(8'd0);
    send_tick(8'd1);
    send_tick(8'd2);
    send_tick(8'd255);
    send_tick(8'd170);
    send_tick(8'd85);
    // Strongest cooling, no sparks, longest delay
    write_all(8'd255, 8'd0, 16'hFFFF, 16'hFFFF);
    repeat (258) send_tick(8'd255);
    write_all(8'd255, 8'd255, 16'd0, 16'd1);
    repeat (4) send_tick(8'd1);
  endtask

  task automatic test_random_settings();
    logic [15:0] delay;
    for (int phase = 0; phase < 5; phase++) begin
      delay = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 40))
                                        : 16'($urandom_range(41, 700));
      write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), delay,
                16'($urandom_range(0, 65535)));
      idle_on = (phase != 2);
      for (int n = 0; n < 30; n++) begin
        // hold off once until the pipeline is empty
        if (phase == 3 && n == 15) begin
          drain_pixels();
        end
        send_tick(8'($urandom_range(0, 255)));
      end
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pix_if.ready <= 1'b0;
    end else begin
      pix_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input int unsigned pix_num,
                             input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: pixel %0d %s mismatch: expected %0d, actual %0d",
               $time, pix_num, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel transaction: expected none, actual idx %0d",
                 $time, pix_if.pixel_index);
      end else begin
        want = pixel_q.pop_front();
        check_field("pixel_index", want.idx, want.idx, pix_if.pixel_index);
        check_field("red", want.idx, want.red, pix_if.red);
        check_field("green", want.idx, want.green, pix_if.green);
        check_field("blue", want.idx, want.blue, pix_if.blue);
        check_field("last_pixel", want.idx, want.last, pix_if.last_pixel);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_MAX) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    errors        = 0;
    idle_on       = 1'b1;
    cooling_q     = COOL_RESET;
    spark_q       = SPARK_RESET;
    delay_q       = DELAY_RESET;
    lfsr_q        = SEED_RESET;
    elapsed_q     = 0;
    foreach (heat_q[i]) heat_q[i] = '0;
    rst           <= 1'b1;
    tick_if.valid <= 1'b0;
    tick_if.ticks <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_COOLING;
    cfg_data      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_register_extremes();
    test_random_settings();
    drain_pixels();

    if (errors == 0 && pixel_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fhe_pkg.sv
sv/fhe_ifs.sv
sv/fhe_ram.sv
sv/fhe_rng.sv
sv/fire_heat_effect.sv
tb/tb_fire_heat_effect.sv
